@@ rtl/core/assert_macros.svh @@
// concurrent check helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define KRVT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// next-cycle implication
`define KRVT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

@@ rtl/core/krvt_pkg.sv @@
`timescale 1ns / 1ps

package krvt_pkg;

   localparam int FRAC_BITS_DEF = 16;

   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 40;

   localparam logic [1:0] OP_PREDICT = 2'd0;
   localparam logic [1:0] OP_UPDATE  = 2'd1;
   localparam logic [1:0] OP_RESET   = 2'd2;

   localparam logic [1:0] CSR_PROCESS_NOISE     = 2'd0;
   localparam logic [1:0] CSR_MEASUREMENT_NOISE = 2'd1;
   localparam logic [1:0] CSR_OUTLIER_THRESHOLD = 2'd2;

   localparam logic [30:0] PROCESS_NOISE_RST     = 31'd655;
   localparam logic [30:0] MEASUREMENT_NOISE_RST = 31'd65536;
   localparam logic [30:0] OUTLIER_THRESHOLD_RST = 31'd196608;

   // 0.01 in Q0.32
   localparam logic [34:0] CONF_EPS = 35'd42949673;
   // reciprocal of ten, used with a shift of 35
   localparam logic [31:0] RECIP_TEN = 32'hCCCCCCCD;

   localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
   localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5,
      ST_U0, ST_U1, ST_U2, ST_U3, ST_U4, ST_U5, ST_U6, ST_U7,
      ST_U8, ST_U9, ST_U10, ST_U11, ST_U12, ST_U13, ST_U14, ST_U15,
      ST_OUT
   } krvt_state_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               clip;
   } krvt_sat_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } krvt_div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } krvt_div_rsp_type;

   function automatic krvt_sat_type sat32(input logic signed [65:0] x);
      krvt_sat_type r;
      if (x > S32_MAX) begin
         r.value = 32'sh7FFFFFFF;
         r.clip  = 1'b1;
      end else if (x < S32_MIN) begin
         r.value = 32'sh80000000;
         r.clip  = 1'b1;
      end else begin
         r.value = x[31:0];
         r.clip  = 1'b0;
      end
      return r;
   endfunction

   function automatic krvt_sat_type satcov(input logic signed [65:0] x);
      krvt_sat_type r;
      if (x > S32_MAX) begin
         r.value = 32'sh7FFFFFFF;
         r.clip  = 1'b1;
      end else if (x < 66'sd0) begin
         r.value = 32'sd0;
         r.clip  = 1'b1;
      end else begin
         r.value = x[31:0];
         r.clip  = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] x);
      logic signed [31:0] n;
      n = -x;
      return x[31] ? n : x;
   endfunction

   function automatic logic [31:0] mag33(input logic signed [32:0] x);
      logic signed [32:0] n;
      n = -x;
      return x[32] ? n[31:0] : x[31:0];
   endfunction

endpackage

@@ rtl/core/krvt_channels_if.sv @@
`timescale 1ns / 1ps

interface krvt_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic [23:0]        dt;
   logic signed [31:0] measurement;
   logic [16:0]        confidence;
   logic signed [31:0] reset_distance;
   logic signed [31:0] reset_velocity;

   modport source (output valid, op, dt, measurement, confidence, reset_distance,
                   reset_velocity, input ready);
   modport sink (input valid, op, dt, measurement, confidence, reset_distance,
                 reset_velocity, output ready);
endinterface

interface krvt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] distance;
   logic signed [31:0] velocity;
   logic [30:0]        distance_variance;
   logic signed [31:0] innovation;
   logic               outlier;
   logic               saturated;

   modport source (output valid, distance, velocity, distance_variance, innovation,
                   outlier, saturated, input ready);
   modport sink (input valid, distance, velocity, distance_variance, innovation,
                 outlier, saturated, output ready);
endinterface

@@ rtl/core/krvt_mul.sv @@
`timescale 1ns / 1ps

module krvt_mul (
   input  logic        clock,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [63:0] product
);

   logic [63:0] product_ff;
   logic [63:0] product_in;

   assign product_in = 64'(a) * 64'(b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

@@ rtl/core/krvt_div.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module krvt_div (
   input  logic                        clock,
   input  logic                        reset,
   input  krvt_pkg::krvt_div_req_type  div_req,
   output krvt_pkg::krvt_div_rsp_type  div_rsp
);

   localparam int NW = krvt_pkg::DIV_NUM_W;
   localparam int DW = krvt_pkg::DIV_DEN_W;
   localparam int CW = $clog2(NW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] count_ff, count_in;
   logic [NW-1:0] work_ff, work_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dsr_ff, dsr_in;
   logic [DW:0]   trial;
   logic          take;

   assign trial = {rem_ff, work_ff[NW-1]};
   assign take  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      if (busy_ff) begin
         // one quotient bit per cycle
         rem_in   = take ? DW'(trial - {1'b0, dsr_ff}) : trial[DW-1:0];
         work_in  = {work_ff[NW-2:0], take};
         count_in = count_ff + CW'(1);
         if (count_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         work_in  = div_req.dividend;
         rem_in   = '0;
         dsr_in   = div_req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = work_ff;

   `KRVT_ASSERT_NEXT(a_start_busy, clock, reset, div_req.start && !busy_ff, busy_ff)
   `KRVT_ASSERT_IMPL(a_done_idle, clock, reset, done_ff, !busy_ff)
   `KRVT_ASSERT_IMPL(a_done_after_busy, clock, reset, done_ff, $past(busy_ff))

endmodule

@@ rtl/core/kalman_range_velocity_tracker_core.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Predict runs P0 to P5 and update runs U0 to U15 (ending early when P00 plus
// adapted noise is zero); reset and unused ops go straight to the result.
// Throughput: one word in flight; the next can be taken in the cycle after the result
// is taken. Update time is set by the 64-step serial divider, run up to three times.
// Reset: synchronous; state returns to identity covariance, registers to defaults.

module kalman_range_velocity_tracker_core #(
   parameter int FRAC_BITS = krvt_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   krvt_req_if.sink          req_chan,
   krvt_rsp_if.source        rsp_chan,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [30:0]       csr_wdata
);

   localparam logic [64:0] HALF_Q = 65'(1) << (FRAC_BITS - 1);
   localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

   krvt_pkg::krvt_state_type state_ff, state_in;

   logic [30:0] pn_ff, pn_in, mn_ff, mn_in, th_ff, th_in;
   logic signed [31:0] ed_ff, ed_in, ev_ff, ev_in;
   logic signed [31:0] cdd_ff, cdd_in, cdv_ff, cdv_in, cvv_ff, cvv_in;
   logic signed [31:0] ndv_ff, ndv_in, n00_ff, n00_in, n11_ff, n11_in;
   logic signed [31:0] k1_ff, k1_in, innov_ff, innov_in;
   logic [31:0]        k0_ff, k0_in;
   logic signed [65:0] acc_ff, acc_in;
   logic [23:0]        dt_ff, dt_in;
   logic [16:0]        conf_ff, conf_in;
   logic signed [32:0] y_ff, y_in;
   logic [34:0]        den_ff, den_in;
   logic [63:0]        y2_ff, y2_in, wlo_ff, wlo_in;
   logic [61:0]        t_ff, t_in;
   logic [39:0]        s_ff, s_in;
   logic               outl_ff, outl_in, sat_ff, sat_in, neg_ff, neg_in;

   logic [31:0]        mul_a, mul_b;
   logic [63:0]        mul_p;
   logic [64:0]        p_round;
   logic signed [65:0] rq;
   logic [31:0]        s0;
   logic [39:0]        s_cur;
   logic [127:0]       lhs, rhs;
   logic signed [65:0] acc_adj;
   logic signed [65:0] qs;
   logic               req_acc, rsp_acc;
   krvt_pkg::krvt_sat_type sr;

   krvt_pkg::krvt_div_req_type div_req;
   krvt_pkg::krvt_div_rsp_type div_rsp;

   krvt_mul u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .product (mul_p)
   );

   krvt_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_acc = req_chan.valid && req_chan.ready;
   assign rsp_acc = rsp_chan.valid && rsp_chan.ready;

   assign p_round = ({1'b0, mul_p} + HALF_Q) >> FRAC_BITS;
   assign rq      = neg_ff ? -$signed({1'b0, p_round}) : $signed({1'b0, p_round});
   assign s0      = {1'b0, cdd_ff[30:0]} + {1'b0, mn_ff};
   assign s_cur   = 40'(cdd_ff[30:0]) + div_rsp.quotient[39:0];
   assign lhs     = 128'(y2_ff) << FRAC_BITS;
   assign rhs     = (128'(mul_p) << 32) + 128'(wlo_ff);
   assign acc_adj = acc_ff + 66'(acc_ff[65]);
   assign qs      = $signed({2'b00, div_rsp.quotient});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         krvt_pkg::ST_IDLE: begin
            if (req_acc) begin
               case (req_chan.op)
                  krvt_pkg::OP_PREDICT: state_in = krvt_pkg::ST_P0;
                  krvt_pkg::OP_UPDATE:  state_in = krvt_pkg::ST_U0;
                  default:              state_in = krvt_pkg::ST_OUT;
               endcase
            end
         end
         krvt_pkg::ST_P0:  state_in = krvt_pkg::ST_P1;
         krvt_pkg::ST_P1:  state_in = krvt_pkg::ST_P2;
         krvt_pkg::ST_P2:  state_in = krvt_pkg::ST_P3;
         krvt_pkg::ST_P3:  state_in = krvt_pkg::ST_P4;
         krvt_pkg::ST_P4:  state_in = krvt_pkg::ST_P5;
         krvt_pkg::ST_P5:  state_in = krvt_pkg::ST_OUT;
         krvt_pkg::ST_U0:  state_in = krvt_pkg::ST_U1;
         krvt_pkg::ST_U1:  state_in = krvt_pkg::ST_U2;
         krvt_pkg::ST_U2:  state_in = krvt_pkg::ST_U3;
         krvt_pkg::ST_U3:  state_in = krvt_pkg::ST_U4;
         krvt_pkg::ST_U4:  state_in = krvt_pkg::ST_U5;
         krvt_pkg::ST_U5:  state_in = krvt_pkg::ST_U6;
         krvt_pkg::ST_U6: begin
            if (div_rsp.done) begin
               state_in = (s_cur == '0) ? krvt_pkg::ST_OUT : krvt_pkg::ST_U7;
            end
         end
         krvt_pkg::ST_U7: begin
            if (div_rsp.done) state_in = krvt_pkg::ST_U8;
         end
         krvt_pkg::ST_U8: begin
            if (div_rsp.done) state_in = krvt_pkg::ST_U9;
         end
         krvt_pkg::ST_U9:  state_in = krvt_pkg::ST_U10;
         krvt_pkg::ST_U10: state_in = krvt_pkg::ST_U11;
         krvt_pkg::ST_U11: state_in = krvt_pkg::ST_U12;
         krvt_pkg::ST_U12: state_in = krvt_pkg::ST_U13;
         krvt_pkg::ST_U13: state_in = krvt_pkg::ST_U14;
         krvt_pkg::ST_U14: state_in = krvt_pkg::ST_U15;
         krvt_pkg::ST_U15: state_in = krvt_pkg::ST_OUT;
         krvt_pkg::ST_OUT: begin
            if (rsp_acc) state_in = krvt_pkg::ST_IDLE;
         end
         default: state_in = krvt_pkg::ST_IDLE;
      endcase
   end

   // unit controls
   always_comb begin
      mul_a            = '0;
      mul_b            = '0;
      neg_in           = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      case (state_ff)
         krvt_pkg::ST_P0: begin
            mul_a  = krvt_pkg::mag32(ev_ff);
            mul_b  = 32'(dt_ff);
            neg_in = ev_ff[31];
         end
         krvt_pkg::ST_P1: begin
            mul_a = 32'(dt_ff);
            mul_b = cvv_ff;
         end
         krvt_pkg::ST_P2: begin
            mul_a  = 32'(dt_ff);
            mul_b  = krvt_pkg::mag32(cdv_ff);
            neg_in = cdv_ff[31];
         end
         krvt_pkg::ST_P3: begin
            mul_a  = 32'(dt_ff);
            mul_b  = krvt_pkg::mag32(ndv_ff);
            neg_in = ndv_ff[31];
         end
         krvt_pkg::ST_P4: begin
            mul_a = 32'(pn_ff);
            mul_b = krvt_pkg::RECIP_TEN;
         end
         krvt_pkg::ST_U0: begin
            mul_a = 32'(conf_ff);
            mul_b = 32'(conf_ff);
         end
         krvt_pkg::ST_U1: begin
            mul_a = krvt_pkg::mag33(y_ff);
            mul_b = krvt_pkg::mag33(y_ff);
         end
         krvt_pkg::ST_U2: begin
            mul_a = 32'(th_ff);
            mul_b = 32'(th_ff);
         end
         krvt_pkg::ST_U3: begin
            mul_a = mul_p[31:0];
            mul_b = s0;
         end
         krvt_pkg::ST_U4: begin
            mul_a = 32'(t_ff[61:32]);
            mul_b = s0;
         end
         krvt_pkg::ST_U5: begin
            div_req.start    = 1'b1;
            div_req.dividend = ({1'b0, mn_ff, 32'd0}) + 64'(den_ff >> 1);
            div_req.divisor  = 40'(den_ff);
         end
         krvt_pkg::ST_U6: begin
            div_req.start    = div_rsp.done && (s_cur != '0);
            div_req.dividend = (64'(cdd_ff[30:0]) << FRAC_BITS) + 64'(s_cur >> 1);
            div_req.divisor  = s_cur;
         end
         krvt_pkg::ST_U7: begin
            div_req.start    = div_rsp.done;
            div_req.dividend = (64'(krvt_pkg::mag32(cdv_ff)) << FRAC_BITS)
                               + 64'(s_ff >> 1);
            div_req.divisor  = s_ff;
         end
         krvt_pkg::ST_U9: begin
            mul_a  = k0_ff;
            mul_b  = krvt_pkg::mag32(cdv_ff);
            neg_in = cdv_ff[31];
         end
         krvt_pkg::ST_U10: begin
            mul_a  = krvt_pkg::mag32(k1_ff);
            mul_b  = cdd_ff;
            neg_in = k1_ff[31];
         end
         krvt_pkg::ST_U11: begin
            mul_a = k0_ff;
            mul_b = cdd_ff;
         end
         krvt_pkg::ST_U12: begin
            mul_a  = krvt_pkg::mag32(k1_ff);
            mul_b  = krvt_pkg::mag32(cdv_ff);
            neg_in = k1_ff[31] ^ cdv_ff[31];
         end
         krvt_pkg::ST_U13: begin
            mul_a  = k0_ff;
            mul_b  = krvt_pkg::mag33(y_ff);
            neg_in = y_ff[32];
         end
         krvt_pkg::ST_U14: begin
            mul_a  = krvt_pkg::mag32(k1_ff);
            mul_b  = krvt_pkg::mag33(y_ff);
            neg_in = k1_ff[31] ^ y_ff[32];
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // datapath
   always_comb begin
      pn_in    = pn_ff;
      mn_in    = mn_ff;
      th_in    = th_ff;
      ed_in    = ed_ff;
      ev_in    = ev_ff;
      cdd_in   = cdd_ff;
      cdv_in   = cdv_ff;
      cvv_in   = cvv_ff;
      ndv_in   = ndv_ff;
      n00_in   = n00_ff;
      n11_in   = n11_ff;
      k0_in    = k0_ff;
      k1_in    = k1_ff;
      innov_in = innov_ff;
      acc_in   = acc_ff;
      dt_in    = dt_ff;
      conf_in  = conf_ff;
      y_in     = y_ff;
      den_in   = den_ff;
      y2_in    = y2_ff;
      wlo_in   = wlo_ff;
      t_in     = t_ff;
      s_in     = s_ff;
      outl_in  = outl_ff;
      sat_in   = sat_ff;
      sr       = '0;

      if (csr_we) begin
         case (csr_index)
            krvt_pkg::CSR_PROCESS_NOISE:     pn_in = csr_wdata;
            krvt_pkg::CSR_MEASUREMENT_NOISE: mn_in = csr_wdata;
            krvt_pkg::CSR_OUTLIER_THRESHOLD: th_in = csr_wdata;
            default: pn_in = pn_ff;
         endcase
      end

      case (state_ff)
         krvt_pkg::ST_IDLE: begin
            if (req_acc) begin
               sat_in   = 1'b0;
               outl_in  = 1'b0;
               innov_in = '0;
               dt_in    = req_chan.dt;
               conf_in  = req_chan.confidence;
               y_in     = 33'(req_chan.measurement) - 33'(ed_ff);
               if (req_chan.op == krvt_pkg::OP_UPDATE) begin
                  sr       = krvt_pkg::sat32(66'(y_in));
                  innov_in = sr.value;
                  sat_in   = sr.clip;
               end
               if (req_chan.op == krvt_pkg::OP_RESET) begin
                  ed_in  = req_chan.reset_distance;
                  ev_in  = req_chan.reset_velocity;
                  cdd_in = ONE_Q;
                  cdv_in = '0;
                  cvv_in = ONE_Q;
               end
            end
         end
         krvt_pkg::ST_P1: begin
            sr     = krvt_pkg::sat32(66'(ed_ff) + rq);
            ed_in  = sr.value;
            sat_in = sat_ff | sr.clip;
         end
         krvt_pkg::ST_P2: begin
            sr     = krvt_pkg::sat32(66'(cdv_ff) + rq);
            ndv_in = sr.value;
            sat_in = sat_ff | sr.clip;
            acc_in = 66'(cdd_ff) + $signed(66'(pn_ff));
         end
         krvt_pkg::ST_P3, krvt_pkg::ST_P4: begin
            acc_in = acc_ff + rq;
         end
         krvt_pkg::ST_P5: begin
            sr     = krvt_pkg::satcov(acc_ff);
            cdd_in = sr.value;
            sat_in = sat_ff | sr.clip;
            cdv_in = ndv_ff;
            sr     = krvt_pkg::satcov(66'(cvv_ff) + $signed(66'(mul_p[63:35])));
            cvv_in = sr.value;
            sat_in = sat_in | sr.clip;
         end
         krvt_pkg::ST_U1: den_in = 35'(mul_p[33:0]) + krvt_pkg::CONF_EPS;
         krvt_pkg::ST_U2: y2_in  = mul_p;
         krvt_pkg::ST_U3: t_in   = mul_p[61:0];
         krvt_pkg::ST_U4: wlo_in = mul_p;
         krvt_pkg::ST_U5: outl_in = lhs > rhs;
         krvt_pkg::ST_U6: begin
            if (div_rsp.done) s_in = s_cur;
         end
         krvt_pkg::ST_U7: begin
            if (div_rsp.done) k0_in = div_rsp.quotient[31:0];
         end
         krvt_pkg::ST_U8: begin
            if (div_rsp.done) begin
               sr     = krvt_pkg::sat32(cdv_ff[31] ? -qs : qs);
               k1_in  = sr.value;
               sat_in = sat_ff | sr.clip;
            end
         end
         krvt_pkg::ST_U10: acc_in = 66'(cdv_ff) - rq;
         krvt_pkg::ST_U11: acc_in = acc_ff + 66'(cdv_ff) - rq;
         krvt_pkg::ST_U12: begin
            sr     = krvt_pkg::satcov(66'(cdd_ff) - rq);
            n00_in = sr.value;
            sat_in = sat_ff | sr.clip;
         end
         krvt_pkg::ST_U13: begin
            sr     = krvt_pkg::satcov(66'(cvv_ff) - rq);
            n11_in = sr.value;
            sat_in = sat_ff | sr.clip;
         end
         krvt_pkg::ST_U14: begin
            sr     = krvt_pkg::sat32(66'(ed_ff) + rq);
            ed_in  = sr.value;
            sat_in = sat_ff | sr.clip;
         end
         krvt_pkg::ST_U15: begin
            sr     = krvt_pkg::sat32(66'(ev_ff) + rq);
            ev_in  = sr.value;
            sat_in = sat_ff | sr.clip;
            sr     = krvt_pkg::sat32(acc_adj >>> 1);
            cdv_in = sr.value;
            sat_in = sat_in | sr.clip;
            cdd_in = n00_ff;
            cvv_in = n11_ff;
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= krvt_pkg::ST_IDLE;
         pn_ff    <= krvt_pkg::PROCESS_NOISE_RST;
         mn_ff    <= krvt_pkg::MEASUREMENT_NOISE_RST;
         th_ff    <= krvt_pkg::OUTLIER_THRESHOLD_RST;
         ed_ff    <= '0;
         ev_ff    <= '0;
         cdd_ff   <= ONE_Q;
         cdv_ff   <= '0;
         cvv_ff   <= ONE_Q;
      end else begin
         state_ff <= state_in;
         pn_ff    <= pn_in;
         mn_ff    <= mn_in;
         th_ff    <= th_in;
         ed_ff    <= ed_in;
         ev_ff    <= ev_in;
         cdd_ff   <= cdd_in;
         cdv_ff   <= cdv_in;
         cvv_ff   <= cvv_in;
      end
      ndv_ff   <= ndv_in;
      n00_ff   <= n00_in;
      n11_ff   <= n11_in;
      k0_ff    <= k0_in;
      k1_ff    <= k1_in;
      innov_ff <= innov_in;
      acc_ff   <= acc_in;
      dt_ff    <= dt_in;
      conf_ff  <= conf_in;
      y_ff     <= y_in;
      den_ff   <= den_in;
      y2_ff    <= y2_in;
      wlo_ff   <= wlo_in;
      t_ff     <= t_in;
      s_ff     <= s_in;
      outl_ff  <= outl_in;
      sat_ff   <= sat_in;
      neg_ff   <= neg_in;
   end

   assign req_chan.ready             = (state_ff == krvt_pkg::ST_IDLE);
   assign rsp_chan.valid             = (state_ff == krvt_pkg::ST_OUT);
   assign rsp_chan.distance          = ed_ff;
   assign rsp_chan.velocity          = ev_ff;
   assign rsp_chan.distance_variance = cdd_ff[30:0];
   assign rsp_chan.innovation        = innov_ff;
   assign rsp_chan.outlier           = outl_ff;
   assign rsp_chan.saturated         = sat_ff;

   `KRVT_ASSERT_IMPL(a_one_word, clock, reset, rsp_chan.valid, !req_chan.ready)
   `KRVT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_acc, !req_chan.ready)
   `KRVT_ASSERT_NEXT(a_idle_after_result, clock, reset, rsp_acc, req_chan.ready)

endmodule
